@@ rtl/drum_step_sequencer_swing_defines.svh @@
// assertion macros shared by the checker
`ifndef DRUM_STEP_SEQUENCER_SWING_DEFINES_SVH
`define DRUM_STEP_SEQUENCER_SWING_DEFINES_SVH

// checked outside reset
`define DSS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked on every edge, reset included
`define DSS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

@@ rtl/dss_pkg.sv @@
package dss_pkg;

    localparam int NUM_ROWS   = 6;
    localparam int NUM_STEPS  = 16;
    localparam int ROW_W      = 3;
    localparam int COL_W      = 4;
    localparam int STEP_W     = $clog2(NUM_STEPS);
    localparam int COUNT_W    = 16;
    localparam int FRAC_W     = 8;
    localparam int SWING_W    = 6;
    localparam int MASK_W     = 6;
    localparam int IDX_W      = 4;
    localparam int PROD_W     = 15;
    localparam int SWING_SCALE = 100;
    localparam int PADDR_W    = 2;
    localparam int PDATA_W    = 32;

    localparam logic [PADDR_W-1:0] REG_SWING_ADDR = 2'd0;

    typedef enum logic [1:0] {
        FUNC_TICK   = 2'd0,
        FUNC_TOGGLE = 2'd1,
        FUNC_SET    = 2'd2,
        FUNC_CLEAR  = 2'd3
    } func_t;

    typedef struct packed {
        func_t                func;
        logic [COUNT_W-1:0]   sixteenth_count;
        logic [FRAC_W-1:0]    sixteenth_fraction;
        logic [ROW_W-1:0]     row;
        logic [COL_W-1:0]     column;
        logic                 cell_value;
    } in_item_t;

    typedef struct packed {
        logic [MASK_W-1:0]    trigger_mask;
        logic [IDX_W-1:0]     step_index;
        logic                 is_audition;
    } out_item_t;

    typedef struct packed {
        logic                 en;
        func_t                func;
        logic [ROW_W-1:0]     row;
        logic [COL_W-1:0]     col;
        logic                 val;
    } edit_t;

    typedef struct packed {
        logic [NUM_ROWS-1:0]  col_mask;
        logic                 in_range;
        logic                 cell_on;
    } grid_stat_t;

    typedef struct packed {
        logic                 fire;
        logic [STEP_W-1:0]    step_new;
        logic [STEP_W-1:0]    playhead;
    } play_stat_t;

    // built-in groove, bit c is column c
    function automatic logic [NUM_STEPS-1:0] groove_row(input int unsigned r);
        logic [15:0] w;
        case (r)
            0:       w = 16'h1111;
            1:       w = 16'h1010;
            2:       w = 16'h5555;
            3:       w = 16'h4000;
            4:       w = 16'h0000;
            5:       w = 16'h4141;
            default: w = 16'h0000;
        endcase
        return NUM_STEPS'(w);
    endfunction

endpackage

@@ rtl/dss_cfg.sv @@
module dss_cfg import dss_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready,
    output logic [SWING_W-1:0]   swing_percent
);

    logic [SWING_W-1:0] swing_reg;
    logic               wr_swing;

    assign pready   = 1'b1;
    assign wr_swing = psel && penable && pwrite && (paddr == REG_SWING_ADDR);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            swing_reg <= '0;
        end else if (wr_swing) begin
            swing_reg <= pwdata[SWING_W-1:0];
        end
    end

    always_comb begin
        unique case (paddr)
            REG_SWING_ADDR: prdata = PDATA_W'(swing_reg);
            default:        prdata = '0;
        endcase
    end

    assign swing_percent = swing_reg;

endmodule

@@ rtl/dss_grid.sv @@
module dss_grid import dss_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  edit_t             edit,
    input  logic [STEP_W-1:0] rd_col,
    output grid_stat_t        stat
);

    logic [NUM_STEPS-1:0] grid_reg [NUM_ROWS];
    logic                 in_range;
    logic                 old_bit;
    logic                 new_bit;

    assign in_range = ({1'b0, edit.row} < (ROW_W+1)'(NUM_ROWS))
                   && ({1'b0, edit.col} < (COL_W+1)'(NUM_STEPS));
    assign old_bit  = in_range ? grid_reg[edit.row][edit.col] : 1'b0;
    assign new_bit  = (edit.func == FUNC_TOGGLE) ? ~old_bit : edit.val;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < NUM_ROWS; r++) begin
                grid_reg[r] <= groove_row(r);
            end
        end else if (edit.en) begin
            unique case (edit.func) inside
                FUNC_CLEAR: begin
                    for (int r = 0; r < NUM_ROWS; r++) begin
                        grid_reg[r] <= '0;
                    end
                end
                FUNC_TOGGLE, FUNC_SET: begin
                    if (in_range) begin
                        grid_reg[edit.row][edit.col] <= new_bit;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int r = 0; r < NUM_ROWS; r++) begin
            stat.col_mask[r] = grid_reg[r][rd_col];
        end
        stat.in_range = in_range;
        stat.cell_on  = new_bit;
    end

endmodule

@@ rtl/dss_play.sv @@
module dss_play import dss_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               tick_en,
    input  logic [COUNT_W-1:0] count,
    input  logic [FRAC_W-1:0]  frac,
    input  logic [SWING_W-1:0] swing_percent,
    output play_stat_t         stat
);

    logic [COUNT_W-1:0] last_fired_reg;
    logic               fired_once_reg;
    logic [STEP_W-1:0]  playhead_reg;
    logic [PROD_W-1:0]  frac_scaled;
    logic [PROD_W-1:0]  swing_scaled;
    logic               hold_back;
    logic [COUNT_W-1:0] swung;
    logic               fire;
    logic [STEP_W-1:0]  step_new;

    // odd sixteenths are held back while fraction*100 < swing*256
    assign frac_scaled  = PROD_W'(frac) * PROD_W'(SWING_SCALE);
    assign swing_scaled = PROD_W'({swing_percent, 8'd0});
    assign hold_back    = count[0] && (frac_scaled < swing_scaled);
    assign swung        = hold_back ? (count - COUNT_W'(1)) : count;
    assign fire         = !fired_once_reg || (swung != last_fired_reg);
    assign step_new     = STEP_W'(swung % NUM_STEPS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_fired_reg <= '0;
            fired_once_reg <= 1'b0;
            playhead_reg   <= '0;
        end else if (tick_en && fire) begin
            last_fired_reg <= swung;
            fired_once_reg <= 1'b1;
            playhead_reg   <= step_new;
        end
    end

    assign stat.fire     = fire;
    assign stat.step_new = step_new;
    assign stat.playhead = playhead_reg;

endmodule

@@ rtl/drum_step_sequencer_swing.sv @@
// channel | ports            | moves
// --------+------------------+--------------------------------------
// input   | s_valid/s_ready  | in_item_t: tick or grid edit
// output  | m_valid/m_ready  | out_item_t: trigger mask and step
// config  | apb psel/penable | swing_percent at byte address 0
//
// one item per cycle unless the result is stalled; a taken item goes to the
// input register, then through grid/swing logic into the result register
// synchronous active-low reset loads the groove, clears swing and playhead
// a stalled result holds the result register; one more item can wait
// in the input register, then s_ready drops until m_ready returns
module drum_step_sequencer_swing import dss_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_item_t             s_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_item_t            m_item,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready
);

    logic               in_valid_reg;
    in_item_t           in_item_reg;
    logic               m_valid_reg;
    out_item_t          m_item_reg;
    logic               advance;
    logic               is_tick;
    logic [SWING_W-1:0] swing_percent;
    edit_t              edit;
    grid_stat_t         grid_stat;
    play_stat_t         play_stat;
    logic               has_result;
    out_item_t          result;

    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign is_tick = (in_item_reg.func == FUNC_TICK);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
    end

    dss_cfg u_cfg (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .swing_percent (swing_percent)
    );

    dss_play u_play (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .tick_en       (advance && is_tick),
        .count         (in_item_reg.sixteenth_count),
        .frac          (in_item_reg.sixteenth_fraction),
        .swing_percent (swing_percent),
        .stat          (play_stat)
    );

    assign edit.en   = advance && !is_tick;
    assign edit.func = in_item_reg.func;
    assign edit.row  = in_item_reg.row;
    assign edit.col  = in_item_reg.column;
    assign edit.val  = in_item_reg.cell_value;

    dss_grid u_grid (
        .aclk    (aclk),
        .aresetn (aresetn),
        .edit    (edit),
        .rd_col  (play_stat.step_new),
        .stat    (grid_stat)
    );

    always_comb begin
        if (is_tick) begin
            has_result          = play_stat.fire;
            result.trigger_mask = MASK_W'(grid_stat.col_mask);
            result.step_index   = IDX_W'(play_stat.step_new);
            result.is_audition  = 1'b0;
        end else begin
            // audition only when the edit leaves its cell on
            has_result          = (in_item_reg.func != FUNC_CLEAR)
                               && grid_stat.in_range && grid_stat.cell_on;
            result.trigger_mask = MASK_W'(NUM_ROWS'(1) << in_item_reg.row);
            result.step_index   = IDX_W'(play_stat.playhead);
            result.is_audition  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= has_result;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_item_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

@@ rtl/dss_checker.sv @@
`include "drum_step_sequencer_swing_defines.svh"

module dss_checker import dss_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_item
);

    `DSS_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_item), "result dropped or changed while stalled")

    `DSS_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> !m_valid && s_ready, "not idle after reset")

    `DSS_ASSERT(a_audition_onehot, m_valid && m_item.is_audition |-> $onehot(m_item.trigger_mask), "audition mask not one row")

    `DSS_ASSERT(a_stall_cause, !s_ready |-> m_valid && !m_ready, "input stalled without a blocked result")

endmodule

bind drum_step_sequencer_swing dss_checker u_dss_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);
